@@ rtl/core/cal_pkg.sv @@
// Shared types, constants and saturation helpers for the complex accumulate ALU.
package cal_pkg;

    localparam int DATA_W    = 32;              // Q16.16 part width
    localparam int PROD_W    = 64;              // one exact Q32.32 product
    localparam int SUM_W     = 65;              // sum of two products
    localparam int MAG_W     = 49;              // rounded magnitude before saturation
    localparam int FRAC_W    = 16;
    localparam int DIV_STEPS = 33;              // quotient bits (Q.17 before rounding)
    localparam int DIV_CNT_W = 6;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_FEW_OPS  = 2'd2
    } t_status;

    // product schedule of the shared multiplier (a,b = accumulator, c,d = operand)
    typedef enum logic [2:0] {
        P_AC = 3'd0,
        P_BD = 3'd1,
        P_AD = 3'd2,
        P_BC = 3'd3,
        P_CC = 3'd4,
        P_DD = 3'd5
    } t_prod;

    typedef struct packed {
        logic accept;       // latch input item and operation
        logic load_first;   // first item of a run loads the accumulator
        logic addsub;
        logic set_derr;
        logic prod_start;
        logic prod_step;
        logic drain;
        logic mag;
        logic mul_round;
        logic div_start;
        logic div_wr;
        logic count_upd;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic derr;
        t_op  op;
        logic div_zero;
        logic prod_last;
        logic div_done;
        logic out_free;
        logic last;
    } t_stat;

    function automatic logic signed [DATA_W-1:0] sat_addsub(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b,
        input logic                     sub
    );
        logic signed [DATA_W:0] s;
        s = sub ? ({a[DATA_W-1], a} - {b[DATA_W-1], b})
                : ({a[DATA_W-1], a} + {b[DATA_W-1], b});
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return s[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_mag(
        input logic             neg,
        input logic [MAG_W-1:0] mag
    );
        logic [MAG_W-1:0] lim;
        lim = MAG_W'({1'b1, {(DATA_W-1){1'b0}}});
        if (neg) begin
            if (mag >= lim) return {1'b1, {(DATA_W-1){1'b0}}};
            return DATA_W'(~mag[DATA_W-1:0] + 1'b1);
        end
        if (mag >= lim) return {1'b0, {(DATA_W-1){1'b1}}};
        return mag[DATA_W-1:0];
    endfunction

endpackage

@@ rtl/core/cal_div.sv @@
// Restoring divider: one quotient bit per cycle, fixed-point quotient num*2^17/den.
module cal_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [cal_pkg::PROD_W-1:0]       i_num,
    input  logic [cal_pkg::PROD_W-1:0]       i_den,
    output logic                             o_busy,
    output logic [cal_pkg::DIV_STEPS-1:0]    o_quo,
    output logic                             o_ovf
);
    logic [cal_pkg::PROD_W-1:0]    r_rem, n_rem;
    logic [cal_pkg::PROD_W-1:0]    r_den;
    logic [cal_pkg::DIV_STEPS-1:0] r_sh;
    logic [cal_pkg::DIV_STEPS-1:0] r_quo;
    logic [cal_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_ovf;
    logic [cal_pkg::PROD_W:0]      w_trial;
    logic [cal_pkg::PROD_W:0]      w_diff;
    logic                          w_ge;

    assign w_trial = {r_rem, r_sh[cal_pkg::DIV_STEPS-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign n_rem   = w_ge ? w_diff[cal_pkg::PROD_W-1:0] : w_trial[cal_pkg::PROD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= cal_pkg::DIV_CNT_W'(cal_pkg::DIV_STEPS);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != cal_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // integer part >= 2^16 exactly when num/2^16 >= den
            r_ovf <= cal_pkg::PROD_W'(i_num[cal_pkg::PROD_W-1:cal_pkg::FRAC_W]) >= i_den;
            r_rem <= cal_pkg::PROD_W'(i_num[cal_pkg::PROD_W-1:cal_pkg::FRAC_W]);
            r_sh  <= {i_num[cal_pkg::FRAC_W-1:0],
                      {(cal_pkg::DIV_STEPS-cal_pkg::FRAC_W){1'b0}}};
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_sh  <= {r_sh[cal_pkg::DIV_STEPS-2:0], 1'b0};
            r_quo <= {r_quo[cal_pkg::DIV_STEPS-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_ovf  = r_ovf;
endmodule

@@ rtl/core/cal_datapath.sv @@
// Datapath: accumulator, shared multiplier, product sums, dividers and output register.
module cal_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cal_pkg::t_cmd                     i_cmd,
    output cal_pkg::t_stat                    o_stat,
    input  logic                              i_cfg_wen,
    input  logic [1:0]                        i_cfg_wdata,
    input  logic signed [cal_pkg::DATA_W-1:0] i_in_re,
    input  logic signed [cal_pkg::DATA_W-1:0] i_in_im,
    input  logic                              i_in_last,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [cal_pkg::DATA_W-1:0] o_out_re,
    output logic signed [cal_pkg::DATA_W-1:0] o_out_im,
    output logic [1:0]                        o_out_st
);
    localparam int DW = cal_pkg::DATA_W;
    localparam int PW = cal_pkg::PROD_W;
    localparam int SW = cal_pkg::SUM_W;
    localparam int MW = cal_pkg::MAG_W;
    localparam int QW = cal_pkg::DIV_STEPS;

    logic [1:0]             r_operation;
    cal_pkg::t_op           r_op;
    logic signed [DW-1:0]   r_acc_re, r_acc_im;
    logic signed [DW-1:0]   r_c, r_d;
    logic                   r_last;
    logic [1:0]             r_cnt;
    logic                   r_derr;

    cal_pkg::t_prod         r_k, r_pk;
    logic                   r_pv;
    logic signed [PW-1:0]   r_prod;
    logic signed [SW-1:0]   r_sr, r_si, r_sd;
    logic                   r_neg_re, r_neg_im;
    logic [PW-1:0]          r_mag_re, r_mag_im;

    logic                   r_ovalid;
    logic signed [DW-1:0]   r_out_re, r_out_im;
    cal_pkg::t_status       r_out_st;

    logic signed [DW-1:0]   m_x, m_y;
    logic signed [PW-1:0]   w_prod;
    logic signed [SW-1:0]   w_p;
    logic                   w_is_div;
    logic [SW-1:0]          w_rnd_re, w_rnd_im;
    logic                   div_busy_re, div_busy_im;
    logic [QW-1:0]          quo_re, quo_im;
    logic                   ovf_re, ovf_im;
    logic [QW:0]            w_q_re, w_q_im;
    logic [MW-1:0]          w_dmag_re, w_dmag_im;
    cal_pkg::t_status       w_st;
    logic                   w_out_free;

    // shared multiplier operand schedule
    always_comb begin
        case (r_k)
            cal_pkg::P_AC: begin m_x = r_acc_re; m_y = r_c; end
            cal_pkg::P_BD: begin m_x = r_acc_im; m_y = r_d; end
            cal_pkg::P_AD: begin m_x = r_acc_re; m_y = r_d; end
            cal_pkg::P_BC: begin m_x = r_acc_im; m_y = r_c; end
            cal_pkg::P_CC: begin m_x = r_c;      m_y = r_c; end
            cal_pkg::P_DD: begin m_x = r_d;      m_y = r_d; end
            default:       begin m_x = r_acc_re; m_y = r_c; end
        endcase
    end

    assign w_prod   = m_x * m_y;
    assign w_p      = {r_prod[PW-1], r_prod};
    assign w_is_div = (r_op == cal_pkg::OP_DIV);

    // round to nearest, ties away from zero
    assign w_rnd_re = {1'b0, r_mag_re} + SW'(1 << (cal_pkg::FRAC_W - 1));
    assign w_rnd_im = {1'b0, r_mag_im} + SW'(1 << (cal_pkg::FRAC_W - 1));

    assign w_q_re    = {1'b0, quo_re} + 1'b1;
    assign w_q_im    = {1'b0, quo_im} + 1'b1;
    assign w_dmag_re = ovf_re ? MW'({DW{1'b1}}) : MW'(w_q_re[QW:1]);
    assign w_dmag_im = ovf_im ? MW'({DW{1'b1}}) : MW'(w_q_im[QW:1]);

    assign w_out_free = !r_ovalid || i_out_ready;

    always_comb begin
        if (r_cnt != 2'd2)  w_st = cal_pkg::ST_FEW_OPS;
        else if (r_derr)    w_st = cal_pkg::ST_DIV_ZERO;
        else                w_st = cal_pkg::ST_OK;
    end

    cal_div u_div_re (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_mag_re),
        .i_den   (r_sd[PW-1:0]),
        .o_busy  (div_busy_re),
        .o_quo   (quo_re),
        .o_ovf   (ovf_re)
    );

    cal_div u_div_im (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_mag_im),
        .i_den   (r_sd[PW-1:0]),
        .o_busy  (div_busy_im),
        .o_quo   (quo_im),
        .o_ovf   (ovf_im)
    );

    // run state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_operation <= 2'd0;
            r_cnt       <= 2'd0;
            r_derr      <= 1'b0;
            r_acc_re    <= '0;
            r_acc_im    <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_wen) r_operation <= i_cfg_wdata;

            if (i_cmd.load_first) begin
                r_acc_re <= r_c;
                r_acc_im <= r_d;
            end else if (i_cmd.addsub) begin
                r_acc_re <= cal_pkg::sat_addsub(r_acc_re, r_c, r_op == cal_pkg::OP_SUB);
                r_acc_im <= cal_pkg::sat_addsub(r_acc_im, r_d, r_op == cal_pkg::OP_SUB);
            end else if (i_cmd.mul_round) begin
                r_acc_re <= cal_pkg::sat_mag(r_neg_re, w_rnd_re[SW-1:cal_pkg::FRAC_W]);
                r_acc_im <= cal_pkg::sat_mag(r_neg_im, w_rnd_im[SW-1:cal_pkg::FRAC_W]);
            end else if (i_cmd.div_wr) begin
                r_acc_re <= cal_pkg::sat_mag(r_neg_re, w_dmag_re);
                r_acc_im <= cal_pkg::sat_mag(r_neg_im, w_dmag_im);
            end else if (i_cmd.emit) begin
                r_acc_re <= '0;
                r_acc_im <= '0;
            end

            if (i_cmd.set_derr) r_derr <= 1'b1;
            else if (i_cmd.emit) r_derr <= 1'b0;

            if (i_cmd.count_upd && r_cnt != 2'd2) r_cnt <= r_cnt + 1'b1;
            else if (i_cmd.emit) r_cnt <= 2'd0;

            if (i_cmd.emit) r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
        end
    end

    // item, product and magnitude registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_c    <= i_in_re;
            r_d    <= i_in_im;
            r_last <= i_in_last;
            r_op   <= cal_pkg::t_op'(r_operation);
        end

        if (i_cmd.prod_start) begin
            r_k  <= cal_pkg::P_AC;
            r_pv <= 1'b0;
            r_sr <= '0;
            r_si <= '0;
            r_sd <= '0;
        end else if (i_cmd.prod_step || i_cmd.drain) begin
            if (i_cmd.prod_step) begin
                r_prod <= w_prod;
                r_pk   <= r_k;
                r_k    <= cal_pkg::t_prod'(r_k + 1'b1);
                r_pv   <= 1'b1;
            end
            if (r_pv) begin
                case (r_pk)
                    cal_pkg::P_AC: r_sr <= r_sr + w_p;
                    cal_pkg::P_BD: r_sr <= w_is_div ? r_sr + w_p : r_sr - w_p;
                    cal_pkg::P_AD: r_si <= w_is_div ? r_si - w_p : r_si + w_p;
                    cal_pkg::P_BC: r_si <= r_si + w_p;
                    cal_pkg::P_CC: r_sd <= r_sd + w_p;
                    cal_pkg::P_DD: r_sd <= r_sd + w_p;
                    default:       r_sd <= r_sd;
                endcase
            end
        end

        if (i_cmd.mag) begin
            r_neg_re <= r_sr[SW-1];
            r_neg_im <= r_si[SW-1];
            r_mag_re <= r_sr[SW-1] ? PW'(-r_sr) : r_sr[PW-1:0];
            r_mag_im <= r_si[SW-1] ? PW'(-r_si) : r_si[PW-1:0];
        end

        if (i_cmd.emit) begin
            r_out_st <= w_st;
            r_out_re <= (w_st == cal_pkg::ST_OK) ? r_acc_re : '0;
            r_out_im <= (w_st == cal_pkg::ST_OK) ? r_acc_im : '0;
        end
    end

    always_comb begin
        o_stat.cnt_zero  = (r_cnt == 2'd0);
        o_stat.derr      = r_derr;
        o_stat.op        = r_op;
        o_stat.div_zero  = (r_c == '0) && (r_d == '0);
        o_stat.prod_last = (r_k == (w_is_div ? cal_pkg::P_DD : cal_pkg::P_BC));
        o_stat.div_done  = !div_busy_re && !div_busy_im;
        o_stat.out_free  = w_out_free;
        o_stat.last      = r_last;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_re    = r_out_re;
    assign o_out_im    = r_out_im;
    assign o_out_st    = r_out_st;

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("operand count out of range");

    a_derr_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.set_derr |-> (r_op == cal_pkg::OP_DIV))
        else $error("divide error flagged outside divide");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> (!div_busy_re && !div_busy_im))
        else $error("divider restarted while busy");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out_st != cal_pkg::ST_OK) |-> (r_out_re == '0 && r_out_im == '0))
        else $error("error result carries nonzero data");
`endif
endmodule

@@ rtl/core/cal_ctrl.sv @@
// Controller: sequences each item through load, add/sub, multiply or divide.
module cal_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  cal_pkg::t_stat i_stat,
    output cal_pkg::t_cmd  o_cmd
);
    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_DECIDE = 11'b000_0000_0010,
        S_PROD   = 11'b000_0000_0100,
        S_DRAIN  = 11'b000_0000_1000,
        S_MAG    = 11'b000_0001_0000,
        S_MULRND = 11'b000_0010_0000,
        S_DIVGO  = 11'b000_0100_0000,
        S_DIVWT  = 11'b000_1000_0000,
        S_DIVRND = 11'b001_0000_0000,
        S_FIN    = 11'b010_0000_0000,
        S_EMIT   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_FIN;
                if (i_stat.cnt_zero) begin
                    o_cmd.load_first = 1'b1;
                end else if (!i_stat.derr) begin
                    case (i_stat.op)
                        cal_pkg::OP_ADD, cal_pkg::OP_SUB: o_cmd.addsub = 1'b1;
                        cal_pkg::OP_MUL: begin
                            o_cmd.prod_start = 1'b1;
                            n_state          = S_PROD;
                        end
                        cal_pkg::OP_DIV: begin
                            if (i_stat.div_zero) begin
                                o_cmd.set_derr = 1'b1;
                            end else begin
                                o_cmd.prod_start = 1'b1;
                                n_state          = S_PROD;
                            end
                        end
                        default: o_cmd.addsub = 1'b1;
                    endcase
                end
            end
            S_PROD: begin
                o_cmd.prod_step = 1'b1;
                if (i_stat.prod_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                o_cmd.drain = 1'b1;
                n_state     = S_MAG;
            end
            S_MAG: begin
                o_cmd.mag = 1'b1;
                n_state   = (i_stat.op == cal_pkg::OP_MUL) ? S_MULRND : S_DIVGO;
            end
            S_MULRND: begin
                o_cmd.mul_round = 1'b1;
                n_state         = S_FIN;
            end
            S_DIVGO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIVWT;
            end
            S_DIVWT: begin
                if (i_stat.div_done) n_state = S_DIVRND;
            end
            S_DIVRND: begin
                o_cmd.div_wr = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                o_cmd.count_upd = 1'b1;
                n_state         = i_stat.last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
endmodule

@@ rtl/core/complex_accumulate_alu.sv @@
// Top level of the complex accumulate ALU: controller plus datapath.
//
// Folds a run of complex Q16.16 items into one result. The first item of a
// run loads the accumulator; each later item is added, subtracted, multiplied
// or divided in, per the operation register (sampled when the item is taken).
// The item with tlast high closes the run and produces one result item with
// a status in tuser: ok, divide by zero (zero divisor seen; the rest of the
// run is skipped) or too few operands (run of one item). Error results carry
// zero data. Overflow saturates; multiply and divide round to nearest, ties
// away from zero. Items are processed one at a time. The first item of a
// run or an add/subtract passes decide and finish, a multiply takes four
// products through one 32x32 multiplier and a divide takes six products, then
// a 33-step restoring divider, one quotient bit per cycle, for both parts
// in parallel. A closing item waits in the emit state for a free output
// register, which holds a result while the next item is already being taken.
module complex_accumulate_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: operation register (0 add, 1 sub, 2 mul, 3 div)
    input  logic        i_cfg_wen,
    input  logic [1:0]  i_cfg_wdata,
    // item input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] real_part, [63:32] imag_part
    input  logic        s_axis_tlast,   // last_item
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] result_real, [63:32] result_imag
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    cal_pkg::t_cmd  cmd;
    cal_pkg::t_stat stat;

    logic signed [cal_pkg::DATA_W-1:0] out_re, out_im;

    cal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cal_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_re     (s_axis_tdata[31:0]),
        .i_in_im     (s_axis_tdata[63:32]),
        .i_in_last   (s_axis_tlast),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_re    (out_re),
        .o_out_im    (out_im),
        .o_out_st    (m_axis_tuser)
    );

    assign m_axis_tdata = {out_im, out_re};
endmodule

@@ verif/complex_accumulate_alu_tb.sv @@
// Self-checking testbench for the complex accumulate ALU: directed and random runs.
module complex_accumulate_alu_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE_CYCLES = 80;        // longer than a divide item takes

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        cal_pkg::t_status   status;
    } t_folded;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wen;
    logic [1:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;     // [31:0] real_part, [63:32] imag_part
    logic        s_axis_tlast;     // last_item
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;     // [31:0] result_real, [63:32] result_imag
    logic [1:0]  m_axis_tuser;     // [1:0] status

    complex_accumulate_alu dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // shadow of the block: accumulator, run count, error flag, operation
    logic signed [31:0] acc_re;
    logic signed [31:0] acc_im;
    int                 run_count;
    logic               run_div_err;
    cal_pkg::t_op       cur_op;

    t_folded folded_q[$];
    int      mismatches;
    int      cycles;

    // sender and receiver idle control
    bit sender_gaps;
    bit receiver_stalls;
    int hold_request;
    int hold_left;
    int stall_left;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[complex_accumulate_alu] ERROR");
            $finish;
        end
    end

    // saturate a sign and magnitude to Q16.16
    function automatic logic signed [31:0] clamp_mag(input logic neg, input logic [127:0] m);
        if (neg) begin
            if (m >= 128'h8000_0000) return 32'sh8000_0000;
            return -$signed(m[31:0]);
        end
        if (m > 128'h7FFF_FFFF) return 32'sh7FFF_FFFF;
        return m[31:0];
    endfunction

    function automatic logic signed [31:0] clamp_sum(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // round a Q32.32 value to Q16.16, ties away from zero
    function automatic logic signed [31:0] round_prod(input logic signed [65:0] v);
        logic         neg;
        logic [127:0] m;
        neg = v[65];
        m = neg ? -v : v;
        return clamp_mag(neg, (m + 128'd32768) >> 16);
    endfunction

    // rounded, saturated quotient v / den in Q16.16
    function automatic logic signed [31:0] divide_part(input logic signed [65:0] v,
                                                       input logic [127:0] den);
        logic         neg;
        logic [127:0] m;
        logic [127:0] q;
        neg = v[65];
        m = neg ? -v : v;
        if (m / den >= 128'd65536) return clamp_mag(neg, 128'hFFFF_FFFF);
        q = (((m << 17) / den) + 128'd1) >> 1;
        return clamp_mag(neg, q);
    endfunction

    // fold one accepted item into the shadow state; queue the result of a closing item
    task automatic fold_item(input logic signed [31:0] c, input logic signed [31:0] d,
                             input logic last);
        logic signed [65:0] a, b, cw, dw;
        logic [127:0]       den;
        t_folded            r;
        a  = acc_re;
        b  = acc_im;
        cw = c;
        dw = d;
        if (run_count == 0) begin
            acc_re = c;
            acc_im = d;
        end else if (!run_div_err) begin
            case (cur_op)
                cal_pkg::OP_ADD: begin
                    acc_re = clamp_sum(longint'(acc_re) + longint'(c));
                    acc_im = clamp_sum(longint'(acc_im) + longint'(d));
                end
                cal_pkg::OP_SUB: begin
                    acc_re = clamp_sum(longint'(acc_re) - longint'(c));
                    acc_im = clamp_sum(longint'(acc_im) - longint'(d));
                end
                cal_pkg::OP_MUL: begin
                    acc_re = round_prod(a * cw - b * dw);
                    acc_im = round_prod(a * dw + b * cw);
                end
                default: begin
                    if (c == 0 && d == 0) begin
                        run_div_err = 1'b1;
                    end else begin
                        den = cw * cw + dw * dw;
                        acc_re = divide_part(a * cw + b * dw, den);
                        acc_im = divide_part(b * cw - a * dw, den);
                    end
                end
            endcase
        end
        if (run_count < 2) run_count++;
        if (last) begin
            if (run_count < 2) r.status = cal_pkg::ST_FEW_OPS;
            else if (run_div_err) r.status = cal_pkg::ST_DIV_ZERO;
            else r.status = cal_pkg::ST_OK;
            r.re = (r.status == cal_pkg::ST_OK) ? acc_re : 32'sd0;
            r.im = (r.status == cal_pkg::ST_OK) ? acc_im : 32'sd0;
            folded_q = {folded_q, r};
            acc_re = 0;
            acc_im = 0;
            run_count = 0;
            run_div_err = 1'b0;
        end
    endtask

    // result checker, sampled at the rising edge
    always @(posedge i_clk) begin
        t_folded e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (folded_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: re=%h im=%h status=%0d",
                             m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser);
            end else begin
                e = folded_q.pop_front();
                if (m_axis_tdata[31:0] !== e.re || m_axis_tdata[63:32] !== e.im ||
                    m_axis_tuser !== e.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp re=%h im=%h st=%0d, got re=%h im=%h st=%0d",
                                 e.re, e.im, e.status, m_axis_tdata[31:0],
                                 m_axis_tdata[63:32], m_axis_tuser);
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready = 1'b0;
        end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                      : $urandom_range(0, 3);
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    // send one item; returns at the falling edge after it was taken
    task automatic send_item(input logic signed [31:0] c, input logic signed [31:0] d,
                             input logic last);
        int gap;
        gap = 0;
        if (sender_gaps) begin
            case ($urandom_range(0, 9))
                0, 1, 2:    gap = $urandom_range(1, 3);
                3:          gap = $urandom_range(5, 40);
                default:    gap = 0;
            endcase
        end
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {d, c};
        s_axis_tlast  = last;
        do @(posedge i_clk); while (!s_axis_tready);
        fold_item(c, d, last);
        @(negedge i_clk);
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid = 1'b0;
        while (folded_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // operation writes happen only with the block idle
    task automatic set_operation(input cal_pkg::t_op op);
        wait_results_drained();
        i_cfg_wen   = 1'b1;
        i_cfg_wdata = op;
        cur_op      = op;
        @(negedge i_clk);
        i_cfg_wen   = 1'b0;
    endtask

    // operand mix: full range, small, near plus and minus one, extremes, zero
    function automatic logic signed [31:0] pick_part();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2, 3, 4: return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
            5, 6:    return 32'sh1_0000 + $signed($urandom_range(0, 32'hFFFF)) - 32'sh8000;
            7:       return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            8:       return -32'sh1_0000 - $signed($urandom_range(0, 32'hFFFF));
            default: return 32'sd0;
        endcase
    endfunction

    task automatic send_run(input int len);
        logic signed [31:0] c, d;
        for (int i = 0; i < len; i++) begin
            c = pick_part();
            d = pick_part();
            send_item(c, d, i == len - 1);
        end
    endtask

    // extremes for every operation, rounding ties for multiply
    task automatic test_directed_ops();
        set_operation(cal_pkg::OP_ADD);
        send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
        send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);     // both parts saturate
        set_operation(cal_pkg::OP_SUB);
        send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
        send_item(32'sh0000_0001, 32'shFFFF_FFFF, 1'b1);
        set_operation(cal_pkg::OP_MUL);
        send_item(32'sh0001_8000, 32'sh0000_8000, 1'b0);      // 1.5 + 0.5i squared
        send_item(32'sh0001_8000, 32'sh0000_8000, 1'b1);
        send_item(32'sh0000_0001, 32'shFFFF_FFFF, 1'b0);      // ties away from zero
        send_item(32'sh0000_8000, 32'sh0000_0000, 1'b1);
        send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);      // overflow saturates
        send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
        set_operation(cal_pkg::OP_DIV);
        send_item(32'sh0001_0000, 32'sh0000_0000, 1'b0);      // 1 / 3
        send_item(32'sh0003_0000, 32'sh0000_0000, 1'b1);
        send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);      // quotient overflow
        send_item(32'sh0000_0001, 32'sh0000_0000, 1'b1);
        send_item(32'sh0002_0000, 32'shFFFF_0000, 1'b0);
        send_item(32'sh8000_0000, 32'sh8000_0000, 1'b1);
    endtask

    // zero divisor and one-item runs
    task automatic test_special_runs();
        set_operation(cal_pkg::OP_DIV);
        send_item(32'sh0005_0000, 32'sh0001_0000, 1'b0);
        send_item(32'sh0000_0000, 32'sh0000_0000, 1'b0);      // zero divisor
        send_item(32'sh0002_0000, 32'sh0000_0000, 1'b1);      // ignored, still error
        send_item(32'sh0000_0000, 32'sh0000_0000, 1'b1);      // one item: too few operands
        send_item(32'sh1234_5678, 32'shDEAD_BEEF, 1'b1);
        set_operation(cal_pkg::OP_ADD);
        send_item(32'sh0000_0000, 32'sh0000_0000, 1'b1);
    endtask

    // random runs across all operations, some without any idling
    task automatic test_random_runs();
        int sent;
        for (int phase = 0; phase < 16; phase++) begin
            if (phase < 4) set_operation(cal_pkg::t_op'(phase));
            else set_operation(cal_pkg::t_op'($urandom_range(0, 3)));
            sender_gaps     = (phase % 5) != 2;
            receiver_stalls = (phase % 5) != 2;
            sent = 0;
            while (sent < 95) begin
                int len;
                len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 5);
                send_run(len);
                sent += len;
            end
        end
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    // long receiver hold-off while the sender keeps offering, a full drain, then multiply runs
    task automatic test_backpressure();
        set_operation(cal_pkg::OP_ADD);
        sender_gaps  = 1'b0;
        hold_request = 300;
        for (int i = 0; i < 24; i++) send_run(1 + (i % 2));
        s_axis_tvalid = 1'b0;
        while (folded_q.size() != 0) @(negedge i_clk);
        set_operation(cal_pkg::OP_MUL);
        sender_gaps = 1'b1;
        for (int i = 0; i < 10; i++) send_run($urandom_range(1, 4));
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_wen       = 1'b0;
        i_cfg_wdata     = cal_pkg::OP_ADD;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tlast    = 1'b0;
        m_axis_tready   = 1'b0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        hold_request    = 0;
        hold_left       = 0;
        stall_left      = 0;
        mismatches      = 0;
        cycles          = 0;
        acc_re          = 0;
        acc_im          = 0;
        run_count       = 0;
        run_div_err     = 1'b0;
        cur_op          = cal_pkg::OP_ADD;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed_ops();
        test_special_runs();
        test_backpressure();
        test_random_runs();
        set_operation(cal_pkg::OP_DIV);      // leave on the top extreme
        send_run(3);

        wait_results_drained();
        if (mismatches == 0 && folded_q.size() == 0) begin
            $display("[complex_accumulate_alu] OK");
        end else begin
            $display("[complex_accumulate_alu] ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/cal_pkg.sv
rtl/core/cal_div.sv
rtl/core/cal_datapath.sv
rtl/core/cal_ctrl.sv
rtl/core/complex_accumulate_alu.sv
verif/complex_accumulate_alu_tb.sv
